// ===== hdl/rsr_pkg.sv =====
// Package of the reservation station scheduler: opcodes, register indexes,
// reset values and the command bundle from the controller to the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rsr_pkg;

  localparam int DEF_NUM_REGS     = 16;
  localparam int DEF_ADD_STATIONS = 3;
  localparam int DEF_MUL_STATIONS = 2;
  localparam int DEF_DATA_WIDTH   = 32;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_ADDI = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] CFG_ADD_LAT = 2'd0;
  localparam logic [1:0] CFG_SUB_LAT = 2'd1;
  localparam logic [1:0] CFG_MUL_LAT = 2'd2;
  localparam logic [1:0] CFG_DIV_LAT = 2'd3;

  localparam logic [5:0] RST_ADD_LAT = 6'd1;
  localparam logic [5:0] RST_SUB_LAT = 6'd2;
  localparam logic [5:0] RST_MUL_LAT = 6'd10;
  localparam logic [5:0] RST_DIV_LAT = 6'd20;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 80;

  typedef struct packed {
    logic latch;  // capture the input beat
    logic exec;   // run one machine tick
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/rsr_ctrl.sv =====
// Controller of the reservation station scheduler: tick sequencing and the
// output beat valid flag. Depends on rsr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rsr_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        out_ready_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output rsr_pkg::cmd_t    cmd_o
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_o.latch = accept;
  assign cmd_o.exec  = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rsr_divider.sv =====
// Iterative signed divider, two quotient bits per clock, truncating.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rsr_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DATA_WIDTH-1:0] dividend_i,
  input  wire logic [DATA_WIDTH-1:0] divisor_i,
  output logic      [DATA_WIDTH-1:0] quotient_o
);

  localparam int CNT = (DATA_WIDTH + 1) / 2;
  localparam int PW  = 2 * CNT;
  localparam int CW  = $clog2(CNT + 1);

  logic [DATA_WIDTH:0]   rem_q, rem_d;
  logic [PW-1:0]         quo_q, quo_d;
  logic [DATA_WIDTH-1:0] dvs_q;
  logic                  neg_q;
  logic [CW-1:0]         cnt_q;
  logic [DATA_WIDTH-1:0] mag_a, mag_b;

  assign mag_a = dividend_i[DATA_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign mag_b = divisor_i[DATA_WIDTH-1] ? (~divisor_i + 1'b1) : divisor_i;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int s = 0; s < 2; s++) begin
      rem_d = {rem_d[DATA_WIDTH-1:0], quo_d[PW-1]};
      quo_d = {quo_d[PW-2:0], 1'b0};
      if (rem_d >= {1'b0, dvs_q}) begin
        rem_d    = rem_d - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(CNT);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= PW'(mag_a);
      dvs_q <= mag_b;
      neg_q <= dividend_i[DATA_WIDTH-1] ^ divisor_i[DATA_WIDTH-1];
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = neg_q ? (~quo_q[DATA_WIDTH-1:0] + 1'b1) : quo_q[DATA_WIDTH-1:0];

endmodule
`default_nettype wire

// ===== hdl/rsr_datapath.sv =====
// Datapath of the reservation station scheduler: register file, rename table,
// stations, the two units and the output beat. Depends on rsr_pkg, rsr_divider.
`timescale 1ns / 1ps
`default_nettype none
module rsr_datapath #(
  parameter int NUM_REGS     = rsr_pkg::DEF_NUM_REGS,
  parameter int ADD_STATIONS = rsr_pkg::DEF_ADD_STATIONS,
  parameter int MUL_STATIONS = rsr_pkg::DEF_MUL_STATIONS,
  parameter int DATA_WIDTH   = rsr_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rsr_pkg::cmd_t                   cmd_i,
  input  wire logic                            req_i,
  input  wire logic [rsr_pkg::IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [5:0]                      cfg_data_i,
  output logic      [rsr_pkg::OUT_TDATA_W-1:0] out_data_o
);

  localparam int NSTA = ADD_STATIONS + MUL_STATIONS;
  localparam int RW   = $clog2(NUM_REGS);
  localparam int SW   = $clog2(NSTA);
  localparam int DW   = DATA_WIDTH;
  localparam int OUT_TDATA_W_L = rsr_pkg::OUT_TDATA_W;

  function automatic logic [RW-1:0] rix(input logic [3:0] r);
    logic [5:0] v;
    v = {2'b00, r};
    for (int k = 0; k < 8; k++) begin
      if (v >= 6'(NUM_REGS)) v = v - 6'(NUM_REGS);
    end
    return RW'(v);
  endfunction

  function automatic logic [5:0] lat(input logic [5:0] l);
    return (l == 6'd0) ? 6'd1 : l;
  endfunction

  // Latency registers.
  logic [5:0] add_lat_q, sub_lat_q, mul_lat_q, div_lat_q;

  // Latched input beat.
  logic          req_q;
  logic [2:0]    iop_q;
  logic [3:0]    idst_q, isa_q, isb_q;
  logic [31:0]   imm_q;

  // Architectural state.
  logic [DW-1:0] rf_q   [NUM_REGS], rf_d   [NUM_REGS];
  logic          ren_q  [NUM_REGS], ren_d  [NUM_REGS];
  logic          occ_q  [NSTA], occ_d  [NSTA];
  logic          disp_q [NSTA], disp_d [NSTA];
  logic [2:0]    sop_q  [NSTA], sop_d  [NSTA];
  logic [RW-1:0] sdst_q [NSTA], sdst_d [NSTA];
  logic [1:0]    rdy_q  [NSTA], rdy_d  [NSTA];
  logic [DW-1:0] opa_q  [NSTA], opa_d  [NSTA];
  logic [DW-1:0] opb_q  [NSTA], opb_d  [NSTA];

  // Units: index 0 is add/sub, index 1 is mul/div.
  logic          busy_q [2], busy_d [2];
  logic [5:0]    cd_q   [2], cd_d   [2];
  logic [2:0]    uop_q  [2], uop_d  [2];
  logic [RW-1:0] udst_q [2], udst_d [2];
  logic [DW-1:0] ua_q   [2], ua_d   [2];
  logic [DW-1:0] ub_q   [2], ub_d   [2];
  logic          div_start_q, div_start_d;
  logic [DW-1:0] mul_prod_q;
  logic [DW-1:0] div_quo;

  logic [OUT_TDATA_W_L-1:0] out_q, out_d;

  rsr_divider #(.DATA_WIDTH(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (ua_q[1]),
    .divisor_i  (ub_q[1]),
    .quotient_o (div_quo)
  );

  always_comb begin
    logic [5:0]    cdn [2];
    logic          fin [2];
    logic [DW-1:0] ares, mres;
    logic          dz, acc, found;
    logic [SW-1:0] pick;
    logic [RW-1:0] r;
    logic [7:0]    wreg;
    logic [31:0]   aval, mval;
    int            lo, hi;

    rf_d   = rf_q;
    ren_d  = ren_q;
    occ_d  = occ_q;
    disp_d = disp_q;
    sop_d  = sop_q;
    sdst_d = sdst_q;
    rdy_d  = rdy_q;
    opa_d  = opa_q;
    opb_d  = opb_q;
    busy_d = busy_q;
    cd_d   = cd_q;
    uop_d  = uop_q;
    udst_d = udst_q;
    ua_d   = ua_q;
    ub_d   = ub_q;
    div_start_d = 1'b0;
    acc   = 1'b0;
    found = 1'b0;
    pick  = '0;
    r     = '0;

    for (int u = 0; u < 2; u++) begin
      cdn[u] = (busy_q[u] && cd_q[u] != 6'd0) ? cd_q[u] - 6'd1 : cd_q[u];
      cd_d[u] = cdn[u];
      fin[u] = busy_q[u] && (cdn[u] == 6'd0);
    end

    ares = (uop_q[0] == rsr_pkg::OP_SUB) ? ua_q[0] - ub_q[0] : ua_q[0] + ub_q[0];
    dz   = 1'b0;
    if (uop_q[1] == rsr_pkg::OP_DIV) begin
      mres = (ub_q[1] == '0) ? '0 : div_quo;
      dz   = fin[1] && (ub_q[1] == '0);
    end else begin
      mres = mul_prod_q;
    end

    // Writeback, add unit first.
    if (fin[0]) begin
      rf_d[udst_q[0]]  = ares;
      ren_d[udst_q[0]] = 1'b0;
      busy_d[0] = 1'b0;
      cd_d[0]   = 6'd0;
    end
    if (fin[1]) begin
      rf_d[udst_q[1]]  = mres;
      ren_d[udst_q[1]] = 1'b0;
      busy_d[1] = 1'b0;
      cd_d[1]   = 6'd0;
    end
    for (int i = 0; i < NSTA; i++) begin
      for (int u = 0; u < 2; u++) begin
        if (fin[u] && busy_q[u] && occ_q[i] && disp_q[i] &&
            ((u == 0) == (i < ADD_STATIONS))) begin
          occ_d[i]  = 1'b0;
          disp_d[i] = 1'b0;
        end
      end
    end

    // Waiting operands read registers that have no rename entry.
    for (int i = 0; i < NSTA; i++) begin
      if (occ_d[i] && !disp_d[i]) begin
        if (!rdy_d[i][0] && !ren_d[opa_q[i][RW-1:0]]) begin
          opa_d[i]    = rf_d[opa_q[i][RW-1:0]];
          rdy_d[i][0] = 1'b1;
        end
        if (!rdy_d[i][1] && !ren_d[opb_q[i][RW-1:0]]) begin
          opb_d[i]    = rf_d[opb_q[i][RW-1:0]];
          rdy_d[i][1] = 1'b1;
        end
      end
    end

    // Dispatch: each idle unit takes its highest-numbered ready station.
    for (int u = 0; u < 2; u++) begin
      lo = (u == 0) ? 0 : ADD_STATIONS;
      hi = (u == 0) ? ADD_STATIONS : NSTA;
      found = 1'b0;
      pick  = '0;
      for (int i = 0; i < NSTA; i++) begin
        if (i >= lo && i < hi && occ_d[i] && !disp_d[i] && rdy_d[i] == 2'b11) begin
          found = 1'b1;
          pick  = SW'(i);
        end
      end
      if (!busy_d[u] && found) begin
        disp_d[pick] = 1'b1;
        busy_d[u] = 1'b1;
        uop_d[u]  = sop_d[pick];
        udst_d[u] = sdst_d[pick];
        ua_d[u]   = opa_d[pick];
        ub_d[u]   = opb_d[pick];
        case (sop_d[pick])
          rsr_pkg::OP_SUB: cd_d[u] = lat(sub_lat_q);
          rsr_pkg::OP_MUL: cd_d[u] = lat(mul_lat_q);
          rsr_pkg::OP_DIV: cd_d[u] = lat(div_lat_q);
          default:         cd_d[u] = lat(add_lat_q);
        endcase
        if (u == 1) div_start_d = 1'b1;
      end
    end

    // Issue into the lowest free station of the group.
    if (req_q && iop_q <= rsr_pkg::OP_DIV) begin
      lo = (iop_q <= rsr_pkg::OP_SUB) ? 0 : ADD_STATIONS;
      hi = (iop_q <= rsr_pkg::OP_SUB) ? ADD_STATIONS : NSTA;
      found = 1'b0;
      pick  = '0;
      for (int i = NSTA - 1; i >= 0; i--) begin
        if (i >= lo && i < hi && !occ_d[i]) begin
          found = 1'b1;
          pick  = SW'(i);
        end
      end
      if (found) begin
        sop_d[pick]  = iop_q;
        sdst_d[pick] = rix(idst_q);
        r = rix(isa_q);
        if (!ren_d[r]) begin
          opa_d[pick] = rf_d[r];
          rdy_d[pick][0] = 1'b1;
        end else begin
          opa_d[pick] = DW'(r);
          rdy_d[pick][0] = 1'b0;
        end
        if (iop_q == rsr_pkg::OP_ADDI) begin
          opb_d[pick] = imm_q[DW-1:0];
          rdy_d[pick][1] = 1'b1;
        end else begin
          r = rix(isb_q);
          if (!ren_d[r]) begin
            opb_d[pick] = rf_d[r];
            rdy_d[pick][1] = 1'b1;
          end else begin
            opb_d[pick] = DW'(r);
            rdy_d[pick][1] = 1'b0;
          end
        end
        occ_d[pick]  = 1'b1;
        disp_d[pick] = 1'b0;
        ren_d[rix(idst_q)] = 1'b1;
        acc = 1'b1;
      end
    end

    // Result beat.
    out_d = '0;
    out_d[0] = acc;
    out_d[1] = fin[0];
    wreg = 8'(udst_q[0]);
    aval = 32'($signed(ares));
    if (fin[0]) begin
      out_d[5:2]  = wreg[3:0];
      out_d[37:6] = aval;
    end
    out_d[38] = fin[1];
    wreg = 8'(udst_q[1]);
    mval = 32'($signed(mres));
    if (fin[1]) begin
      out_d[42:39] = wreg[3:0];
      out_d[74:43] = mval;
    end
    out_d[75] = dz;
    out_d[76] = 1'b1;
    for (int i = 0; i < NSTA; i++) begin
      if (occ_d[i]) out_d[76] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_lat_q <= rsr_pkg::RST_ADD_LAT;
      sub_lat_q <= rsr_pkg::RST_SUB_LAT;
      mul_lat_q <= rsr_pkg::RST_MUL_LAT;
      div_lat_q <= rsr_pkg::RST_DIV_LAT;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i]  <= '0;
        ren_q[i] <= 1'b0;
      end
      for (int i = 0; i < NSTA; i++) begin
        occ_q[i]  <= 1'b0;
        disp_q[i] <= 1'b0;
      end
      for (int u = 0; u < 2; u++) begin
        busy_q[u] <= 1'b0;
        cd_q[u]   <= 6'd0;
      end
      div_start_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rsr_pkg::CFG_ADD_LAT: add_lat_q <= cfg_data_i;
          rsr_pkg::CFG_SUB_LAT: sub_lat_q <= cfg_data_i;
          rsr_pkg::CFG_MUL_LAT: mul_lat_q <= cfg_data_i;
          rsr_pkg::CFG_DIV_LAT: div_lat_q <= cfg_data_i;
          default: ;
        endcase
      end
      div_start_q <= cmd_i.exec && div_start_d;
      if (cmd_i.exec) begin
        rf_q   <= rf_d;
        ren_q  <= ren_d;
        occ_q  <= occ_d;
        disp_q <= disp_d;
        busy_q <= busy_d;
        cd_q   <= cd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_prod_q <= DW'(ua_q[1] * ub_q[1]);
    if (cmd_i.latch) begin
      req_q  <= req_i;
      iop_q  <= in_data_i[2:0];
      idst_q <= in_data_i[6:3];
      isa_q  <= in_data_i[10:7];
      isb_q  <= in_data_i[14:11];
      imm_q  <= in_data_i[46:15];
    end
    if (cmd_i.exec) begin
      sop_q  <= sop_d;
      sdst_q <= sdst_d;
      rdy_q  <= rdy_d;
      opa_q  <= opa_d;
      opb_q  <= opb_d;
      uop_q  <= uop_d;
      udst_q <= udst_d;
      ua_q   <= ua_d;
      ub_q   <= ub_d;
      out_q  <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== hdl/reservation_station_scheduler_unit.sv =====
// Top level of the reservation station scheduler: stream ports, configuration
// port and assertions. Depends on rsr_pkg, rsr_ctrl, rsr_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Each input beat is one machine tick of a small Tomasulo-style scheduler with
// a register file, a rename table, add/sub and mul/div reservation stations
// and one unit of each kind. The beat is captured into the input registers
// in ST_IDLE, and the whole tick (countdowns, writeback, operand capture,
// dispatch, issue) is evaluated in ST_EXEC, which loads the output register.
// The next beat is taken in ST_IDLE once that register is free or being
// drained, so no beat is taken during a tick. Division runs in an iterative
// unit that produces two quotient bits a clock; it starts right after
// dispatch, and its quotient is used when the divide latency expires, finished or
// not. Latency registers are to be written through the configuration channel while
// the block is idle (not enforced by the block); zero latency acts as the minimum.
module reservation_station_scheduler_unit #(
  parameter int NUM_REGS     = rsr_pkg::DEF_NUM_REGS,
  parameter int ADD_STATIONS = rsr_pkg::DEF_ADD_STATIONS,
  parameter int MUL_STATIONS = rsr_pkg::DEF_MUL_STATIONS,
  parameter int DATA_WIDTH   = rsr_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // opcode[2:0], dest_reg[6:3], src_reg_a[10:7], src_reg_b[14:11],
  // immediate[46:15], zero pad[47]
  input  wire logic [rsr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // req_type[0]
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // accepted[0], add_wb_valid[1], add_wb_reg[5:2], add_wb_value[37:6],
  // mul_wb_valid[38], mul_wb_reg[42:39], mul_wb_value[74:43],
  // div_by_zero[75], pipeline_empty[76], zero pad[79:77]
  output logic      [rsr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [5:0]                      cfg_data_i
);

  rsr_pkg::cmd_t cmd;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  rsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  rsr_datapath #(
    .NUM_REGS     (NUM_REGS),
    .ADD_STATIONS (ADD_STATIONS),
    .MUL_STATIONS (MUL_STATIONS),
    .DATA_WIDTH   (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (m_axis_tdata)
  );

  // A stalled result beat blocks the next tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while a result beat is stalled");

  // Every accepted input beat is followed by a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("result beat missing after a tick");

  // Idle add writeback fields read as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[37:2] == 36'd0))
    else $error("add writeback fields set without a writeback");

endmodule
`default_nettype wire
